// ===== rtl/mhrf_pkg.sv =====
// shared types and constants for the mesh hop receive filter
package mhrf_pkg;

	localparam int unsigned ID_W     = 32;
	localparam int unsigned SEQ_W    = 8;
	localparam int unsigned TTL_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [0:0] {
		REQ_DATA = 1'b0,
		REQ_ACK  = 1'b1
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_ID = 1'b0,
		CFG_ROLE      = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ROLE_HOME = 1'b0,
		ROLE_NODE = 1'b1
	} role_t;

	typedef enum logic [2:0] {
		ST_BUSY          = 3'd0,
		ST_NOT_OURS      = 3'd1,
		ST_DUPLICATE     = 3'd2,
		ST_DELIVERED     = 3'd3,
		ST_FORWARDED     = 3'd4,
		ST_TTL_EXPIRED   = 3'd5,
		ST_ACK_CONFIRMED = 3'd6,
		ST_ACK_IGNORED   = 3'd7
	} status_t;

	typedef struct packed {
		logic [0:0]       req_type;
		logic [ID_W-1:0]  receiver_id;
		logic [ID_W-1:0]  sender_id;
		logic [ID_W-1:0]  source_id;
		logic [SEQ_W-1:0] seq_num;
		logic [TTL_W-1:0] ttl;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic             ack_send;
		logic [ID_W-1:0]  ack_dest;
		logic [SEQ_W-1:0] ack_seq;
		logic [TTL_W-1:0] fwd_ttl;
	} result_t;

	typedef enum logic [1:0] {
		CS_IDLE   = 2'd0,
		CS_MATCH  = 2'd1,
		CS_DECIDE = 2'd2
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic decide;
	} dp_cmd_t;

endpackage

// ===== rtl/mhrf_ctrl.sv =====
// controller state machine: sequences load, compare and decide steps
module mhrf_ctrl
	import mhrf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = CS_MATCH;
				end
			end
			CS_MATCH:  state_d = CS_DECIDE;
			CS_DECIDE: state_d = CS_IDLE;
			default:   state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		cmd.load    = 1'b0;
		cmd.compare = 1'b0;
		cmd.decide  = 1'b0;
		case (state_q)
			CS_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			CS_MATCH:  cmd.compare = 1'b1;
			CS_DECIDE: cmd.decide = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

endmodule

// ===== rtl/mhrf_datapath.sv =====
// datapath: config registers, seen-pair ring, ack wait and result register
module mhrf_datapath
	import mhrf_pkg::*;
#(
	parameter int unsigned SEEN_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  req_t                  req,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output result_t               result
);

	localparam int unsigned PTR_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SEEN_DEPTH - 1);

	logic [ID_W-1:0]       device_id_q;
	role_t                 role_q;
	req_t                  item_s1;
	logic [SEEN_DEPTH-1:0] match_d;
	logic [SEEN_DEPTH-1:0] match_s2;
	logic [ID_W-1:0]       seen_src_q [SEEN_DEPTH];
	logic [SEQ_W-1:0]      seen_seq_q [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] seen_vld_q;
	logic [PTR_W-1:0]      ptr_q;
	logic                  awaiting_q;
	logic [SEQ_W-1:0]      awaited_seq_q;
	logic                  res_valid_q;
	result_t               result_q;

	result_t res_d;
	logic    record;
	logic    arm;
	logic    disarm;
	logic    dev_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
			role_q      <= ROLE_NODE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DEVICE_ID: device_id_q <= cfg_data[ID_W-1:0];
				CFG_ROLE:      role_q <= role_t'(cfg_data[0]);
				default:       role_q <= role_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_s1 <= req;
		end
	end

	// one comparator per ring entry
	always_comb begin
		for (int unsigned i = 0; i < SEEN_DEPTH; i++) begin
			match_d[i] = seen_vld_q[i] && (seen_src_q[i] == item_s1.source_id)
				&& (seen_seq_q[i] == item_s1.seq_num);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_s2 <= match_d;
		end
	end

	always_comb begin
		dev_hit          = (item_s1.receiver_id == device_id_q);
		record           = 1'b0;
		arm              = 1'b0;
		disarm           = 1'b0;
		res_d.status     = ST_ACK_IGNORED;
		res_d.ack_send   = 1'b0;
		res_d.ack_dest   = '0;
		res_d.ack_seq    = '0;
		res_d.fwd_ttl    = '0;
		if (req_type_t'(item_s1.req_type) == REQ_DATA) begin
			if (awaiting_q) begin
				res_d.status = ST_BUSY;
			end else if (!dev_hit) begin
				res_d.status = ST_NOT_OURS;
			end else begin
				res_d.ack_send = 1'b1;
				res_d.ack_dest = item_s1.sender_id;
				res_d.ack_seq  = item_s1.seq_num;
				if (|match_s2) begin
					res_d.status = ST_DUPLICATE;
				end else begin
					record = 1'b1;
					if (role_q == ROLE_HOME) begin
						res_d.status = ST_DELIVERED;
					end else if (item_s1.ttl == '0) begin
						res_d.status = ST_TTL_EXPIRED;
					end else begin
						res_d.status  = ST_FORWARDED;
						res_d.fwd_ttl = item_s1.ttl - TTL_W'(1);
						arm           = 1'b1;
					end
				end
			end
		end else if (awaiting_q && dev_hit && (awaited_seq_q == item_s1.seq_num)) begin
			res_d.status = ST_ACK_CONFIRMED;
			disarm       = 1'b1;
		end
	end

	// ring payload, no reset: entries are gated by their valid bits
	always_ff @(posedge clk) begin
		if (cmd.decide && record) begin
			seen_src_q[ptr_q] <= item_s1.source_id;
			seen_seq_q[ptr_q] <= item_s1.seq_num;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_vld_q    <= '0;
			ptr_q         <= '0;
			awaiting_q    <= 1'b0;
			awaited_seq_q <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= cmd.decide;
			if (cmd.decide && record) begin
				seen_vld_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
			end
			if (cmd.decide && arm) begin
				awaiting_q    <= 1'b1;
				awaited_seq_q <= item_s1.seq_num;
			end else if (cmd.decide && disarm) begin
				awaiting_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			result_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/mesh_hop_receive_filter.sv =====
// top level of the mesh hop receive filter
// a request accepted while idle is loaded, compared against the ring, then
//   decided, and its result is registered and given with a result strobe
// busy is high during the controller's compare and decide steps, so a new
//   request is taken only once the last one has been decided
// reset: arst_n clears the seen ring valid bits, the ack wait and the config registers
//   (device_id 0, role node); the result receiver cannot stall
module mesh_hop_receive_filter
	import mhrf_pkg::*;
#(
	parameter int unsigned SEEN_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  result_valid,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	mhrf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	mhrf_datapath #(
		.SEEN_DEPTH (SEEN_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== rtl/mhrf_checker.sv =====
// port-level checks for the mesh hop receive filter, bound to the top level
module mhrf_checker
	import mhrf_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	// an accepted request occupies the block right away
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted request");

	// every accepted request is followed by its result strobe
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 result_valid)
		else $error("result strobe missing after accepted request");

	// results only appear once the block has gone idle
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// only accepted data requests that reach the ring ask for an ack
	a_no_ack_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_BUSY || result.status == ST_NOT_OURS
			|| result.status == ST_ACK_CONFIRMED || result.status == ST_ACK_IGNORED))
		|-> (!result.ack_send && result.ack_dest == '0 && result.ack_seq == '0))
		else $error("ack requested on a rejected request or an ack");

	// a forward always acks its hop sender
	a_forward_acks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_FORWARDED) |-> result.ack_send)
		else $error("forward without ack");

endmodule

bind mesh_hop_receive_filter mhrf_checker u_mhrf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
